>>> design/rdh_pkg.sv
// shared types and constants for the reuse distance histogram
package rdh_pkg;

  localparam int MAX_BINS_DEF = 64;
  localparam int CNT_W        = 32;
  localparam int DIST_W       = 32;
  localparam int WIDTH_W      = 16;
  localparam int SLOTS_W      = 6;
  localparam int START_W      = 40;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 32;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DISTANCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_SLOTS      = 2'd2;

  // item actions
  localparam logic ACT_RECORD  = 1'b0;
  localparam logic ACT_READOUT = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic latch;
    logic prep;
    logic check;
    logic div_step;
    logic rd_en;
    logic rd_idx;
    logic wr_en;
    logic ro_init;
    logic acc_en;
    logic emit;
    logic emit_first;
    logic emit_last;
  } rdh_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic to_top;
    logic below;
  } rdh_status_t;

endpackage

>>> design/rdh_ram.sv
// generic single write port ram with registered read
module rdh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> design/rdh_ctrl.sv
// controller state machine for record and readout sequencing
module rdh_ctrl
  import rdh_pkg::*;
#(
  parameter int MAX_BINS = MAX_BINS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        in_action,
  input  logic [$clog2(MAX_BINS)-1:0] slots,
  input  rdh_status_t                 st,
  output logic                        busy,
  output rdh_cmd_t                    cmd,
  output logic [$clog2(MAX_BINS)-1:0] addr
);

  localparam int AW = $clog2(MAX_BINS);

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_CHECK,
    S_DIV,
    S_REC_RD,
    S_REC_WR,
    S_SUM,
    S_ROWS,
    S_DRAIN
  } state_t;

  state_t        state_r, state_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic          acc_r, emit_r, first_r, last_r;
  logic          acc_nxt, emit_nxt, first_nxt, last_nxt;
  logic [AW-1:0] top;

  assign top = slots + AW'(1);

  // next state and command decode
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = 1'b0;
    emit_nxt  = 1'b0;
    first_nxt = 1'b0;
    last_nxt  = 1'b0;
    cmd       = '0;
    addr      = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          if (in_action == ACT_READOUT) begin
            cmd.ro_init = 1'b1;
            cnt_nxt     = AW'(1);
            state_nxt   = S_SUM;
          end else begin
            state_nxt = S_PREP;
          end
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (st.to_top || st.below) begin
          state_nxt = S_REC_RD;
        end else begin
          cnt_nxt   = AW'(AW - 1);
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_REC_RD;
        end else begin
          cnt_nxt = cnt_r - AW'(1);
        end
      end
      S_REC_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_idx = 1'b1;
        state_nxt  = S_REC_WR;
      end
      S_REC_WR: begin
        cmd.wr_en = 1'b1;
        state_nxt = S_IDLE;
      end
      S_SUM: begin
        cmd.rd_en = 1'b1;
        acc_nxt   = 1'b1;
        if (cnt_r == top) begin
          cnt_nxt   = '0;
          state_nxt = S_ROWS;
        end else begin
          cnt_nxt = cnt_r + AW'(1);
        end
      end
      S_ROWS: begin
        cmd.rd_en = 1'b1;
        emit_nxt  = 1'b1;
        first_nxt = (cnt_r == '0);
        last_nxt  = (cnt_r == slots);
        if (cnt_r == slots) begin
          state_nxt = S_DRAIN;
        end else begin
          cnt_nxt = cnt_r + AW'(1);
        end
      end
      S_DRAIN: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    // read data arrives in the cycle after the address
    cmd.acc_en     = acc_r;
    cmd.emit       = emit_r;
    cmd.emit_first = first_r;
    cmd.emit_last  = last_r;
  end

  // state and registered command flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      acc_r   <= 1'b0;
      emit_r  <= 1'b0;
      first_r <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      acc_r   <= acc_nxt;
      emit_r  <= emit_nxt;
      first_r <= first_nxt;
      last_r  <= last_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

>>> design/rdh_datapath.sv
// datapath: config registers, bin index divider, bin store and row output
module rdh_datapath
  import rdh_pkg::*;
#(
  parameter int MAX_BINS = MAX_BINS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data,
  input  logic [DIST_W-1:0]           in_distance,
  input  logic                        in_cold,
  input  rdh_cmd_t                    cmd,
  input  logic [$clog2(MAX_BINS)-1:0] addr,
  output rdh_status_t                 st,
  output logic [$clog2(MAX_BINS)-1:0] slots,
  output logic                        out_valid,
  output logic [START_W-1:0]          out_bin_start,
  output logic [CNT_W-1:0]            out_bin_count,
  output logic [CNT_W-1:0]            out_misses_above,
  output logic [CNT_W-1:0]            out_total_records,
  output logic                        out_last
);

  localparam int AW    = $clog2(MAX_BINS);
  localparam int ACC_W = CNT_W + AW;
  localparam int DVS_W = WIDTH_W + AW;
  localparam logic [SLOTS_W-1:0] SLOTS_LIM = SLOTS_W'(MAX_BINS - 2);

  logic [DIST_W-1:0]  first_r;
  logic [WIDTH_W-1:0] width_r;
  logic [SLOTS_W-1:0] nslots_r;
  logic [WIDTH_W-1:0] eff_w;
  logic [SLOTS_W-1:0] slots_lim;

  logic [DIST_W-1:0]  dist_r;
  logic               cold_r;
  logic [START_W-1:0] bound_r;
  logic [DIST_W:0]    diff_r;
  logic [DVS_W-1:0]   span;
  logic [DIST_W-1:0]  rem_r;
  logic [DVS_W-1:0]   dvs_r;
  logic [AW-1:0]      q_r;
  logic [AW-1:0]      q_nxt;
  logic               ge;
  logic [AW-1:0]      idx_r;

  logic [AW-1:0]       raddr;
  logic [CNT_W-1:0]    rdata;
  logic [CNT_W-1:0]    data_m;
  logic [CNT_W-1:0]    wdata;
  logic [MAX_BINS-1:0] valid_r;
  logic                rvld_r;
  logic [CNT_W-1:0]    total_r;

  logic [ACC_W-1:0]   acc_r;
  logic [ACC_W-1:0]   above;
  logic [START_W-1:0] start_r;

  logic               out_valid_r;
  logic [START_W-1:0] out_bin_start_r;
  logic [CNT_W-1:0]   out_bin_count_r;
  logic [CNT_W-1:0]   out_misses_above_r;
  logic [CNT_W-1:0]   out_total_records_r;
  logic               out_last_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r  <= '0;
      width_r  <= WIDTH_W'(1);
      nslots_r <= SLOTS_W'(62);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FIRST_DISTANCE: first_r  <= cfg_data[DIST_W-1:0];
        CFG_BIN_WIDTH:      width_r  <= cfg_data[WIDTH_W-1:0];
        CFG_NUM_SLOTS:      nslots_r <= cfg_data[SLOTS_W-1:0];
        default: ;
      endcase
    end
  end

  // zero width acts as one, slot count limited to the store
  assign eff_w     = (width_r == '0) ? WIDTH_W'(1) : width_r;
  assign slots_lim = (nslots_r > SLOTS_LIM) ? SLOTS_LIM : nslots_r;
  assign slots     = slots_lim[AW-1:0];

  // range classification from registered bound and offset
  assign st.to_top = cold_r || (START_W'(dist_r) > bound_r);
  assign st.below  = diff_r[DIST_W];

  assign span = DVS_W'(slots) * DVS_W'(eff_w);

  // one quotient bit per step, quotient never exceeds the slot count
  assign ge    = (rem_r >= DIST_W'(dvs_r));
  assign q_nxt = {q_r[AW-2:0], ge};

  // record path: latch, bound, classify and divide
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      dist_r <= in_distance;
      cold_r <= in_cold;
    end
    if (cmd.prep) begin
      bound_r <= START_W'(first_r) + START_W'(span);
      diff_r  <= {1'b0, dist_r} - {1'b0, first_r};
    end
    if (cmd.check) begin
      rem_r <= diff_r[DIST_W-1:0];
      dvs_r <= DVS_W'(eff_w) << (AW - 1);
      q_r   <= '0;
      if (st.to_top) begin
        idx_r <= slots + AW'(1);
      end else if (st.below) begin
        idx_r <= '0;
      end
    end
    if (cmd.div_step) begin
      if (ge) begin
        rem_r <= rem_r - DIST_W'(dvs_r);
      end
      dvs_r <= dvs_r >> 1;
      q_r   <= q_nxt;
      idx_r <= q_nxt + AW'(1);
    end
  end

  // bin store
  assign raddr = cmd.rd_idx ? idx_r : addr;
  assign wdata = (data_m == CNT_MAX) ? CNT_MAX : data_m + CNT_W'(1);

  rdh_ram #(
    .WIDTH (CNT_W),
    .DEPTH (MAX_BINS)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (idx_r),
    .wdata (wdata),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  // entries never written read as zero
  assign data_m = rvld_r ? rdata : '0;

  // valid bits and record total
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      rvld_r  <= 1'b0;
      total_r <= '0;
    end else begin
      if (cmd.rd_en) begin
        rvld_r <= valid_r[raddr];
      end
      if (cmd.wr_en) begin
        valid_r[idx_r] <= 1'b1;
        if (total_r != CNT_MAX) begin
          total_r <= total_r + CNT_W'(1);
        end
      end
    end
  end

  // exact suffix sum, peeled one bin per row
  assign above = cmd.emit_first ? acc_r : acc_r - ACC_W'(data_m);

  always_ff @(posedge clk) begin
    priority if (cmd.ro_init) begin
      acc_r   <= '0;
      start_r <= START_W'(first_r);
    end else if (cmd.acc_en) begin
      acc_r <= acc_r + ACC_W'(data_m);
    end else if (cmd.emit) begin
      acc_r   <= above;
      start_r <= start_r + START_W'(eff_w);
    end
  end

  // row output registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_bin_start_r     <= start_r;
      out_bin_count_r     <= data_m;
      out_misses_above_r  <= (|above[ACC_W-1:CNT_W]) ? CNT_MAX : above[CNT_W-1:0];
      out_total_records_r <= total_r;
      out_last_r          <= cmd.emit_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_bin_start     = out_bin_start_r;
  assign out_bin_count     = out_bin_count_r;
  assign out_misses_above  = out_misses_above_r;
  assign out_total_records = out_total_records_r;
  assign out_last          = out_last_r;

endmodule

>>> design/reuse_distance_histogram.sv
// Record: busy through the prep, check, restoring divider, read and write states,
//   skipping the divider when the distance is a cold miss or falls outside the range.
// Readout: busy through a summing pass, a row pass and a drain state; row 0 follows the
//   summing pass, then one row per cycle, the last row in the first idle cycle; the summing
//   pass reads the store through its single read port before the rows.
// Reset: synchronous active low; registers return to 0, 1 and 62, bins read as zero at once.
module reuse_distance_histogram
  import rdh_pkg::*;
#(
  parameter int MAX_BINS = MAX_BINS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_action,
  input  logic [DIST_W-1:0]     in_distance,
  input  logic                  in_cold,
  output logic                  out_valid,
  output logic [START_W-1:0]    out_bin_start,
  output logic [CNT_W-1:0]      out_bin_count,
  output logic [CNT_W-1:0]      out_misses_above,
  output logic [CNT_W-1:0]      out_total_records,
  output logic                  out_last
);

  localparam int AW = $clog2(MAX_BINS);

  rdh_cmd_t      cmd;
  rdh_status_t   st;
  logic [AW-1:0] addr;
  logic [AW-1:0] slots;

  // sequencing
  rdh_ctrl #(
    .MAX_BINS (MAX_BINS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_action (in_action),
    .slots     (slots),
    .st        (st),
    .busy      (busy),
    .cmd       (cmd),
    .addr      (addr)
  );

  // arithmetic and storage
  rdh_datapath #(
    .MAX_BINS (MAX_BINS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_distance       (in_distance),
    .in_cold           (in_cold),
    .cmd               (cmd),
    .addr              (addr),
    .st                (st),
    .slots             (slots),
    .out_valid         (out_valid),
    .out_bin_start     (out_bin_start),
    .out_bin_count     (out_bin_count),
    .out_misses_above  (out_misses_above),
    .out_total_records (out_total_records),
    .out_last          (out_last)
  );

endmodule

>>> design/rdh_checker.sv
// port level checks for the reuse distance histogram, bound to the top level
module rdh_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic out_last
);

  // an accepted item always occupies the block
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("block not busy after accepted transfer");

  // readout rows come out without gaps until the last one
  a_rows_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid)
    else $error("gap inside readout rows");

  // rows before the last are shown while the block is still busy
  a_rows_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy)
    else $error("non-final row while idle");

  // the last row closes a readout
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !out_valid)
    else $error("row transfer right after the last row");

  // a readout begins only out of a busy period
  a_rows_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(busy))
    else $error("row transfer without a readout in progress");

endmodule

bind reuse_distance_histogram rdh_checker u_rdh_checker (.*);
